// ===== hdl/pdfc_pkg.sv =====
package pdfc_pkg;

  // fixed header layout
  localparam int HEADER_LEN = 12;
  localparam int POS_W      = 17;

  localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_SUB    = POS_W'(7);
  localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(8);
  localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(9);
  localparam logic [POS_W-1:0] POS_CK_LO  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_CK_HI  = POS_W'(11);

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_START = 2'd1;
  localparam logic [1:0] STAT_BAD_SUM   = 2'd2;

  // one byte as classified by the front end
  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [15:0] received_checksum;
    logic [15:0] computed_checksum;
    logic [15:0] payload_len;
    logic [7:0]  subsector;
    logic [7:0]  packet_type;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== hdl/pdfc_front.sv =====
module pdfc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // rx_byte
  input  logic           in_tuser,   // first_byte
  output logic           push_valid,
  input  logic           push_ready,
  output pdfc_pkg::item_t push_item
);
  import pdfc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  // input stage: take a byte whenever the stage is empty or draining
  assign in_tready  = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_tvalid && in_tready) begin
      valid_nxt      = 1'b1;
      item_nxt.data  = in_tdata;
      item_nxt.first = in_tuser;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

// ===== hdl/pdfc_queue.sv =====
module pdfc_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  pdfc_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pdfc_pkg::item_t pop_item
);
  import pdfc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push_fire;
  logic               pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty but pointers differ");
`endif

endmodule

// ===== hdl/pdfc_back.sv =====
module pdfc_back #(
  parameter int START_LEN = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [47:0]     start_pattern,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pdfc_pkg::item_t pop_item,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [63:0]     out_tdata,  // packet_type, subsector, payload_len,
                                      // computed_checksum, received_checksum
  output logic [1:0]      out_tuser   // status
);
  import pdfc_pkg::*;

  typedef enum logic [1:0] {
    ST_DISCARD = 2'b01,
    ST_ACTIVE  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         sum_lo_r, sum_lo_nxt;
  logic [7:0]         sum_hi_r, sum_hi_nxt;
  logic [7:0]         type_r, type_nxt;
  logic [7:0]         sub_r, sub_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [15:0]        ck_r, ck_nxt;
  logic               bad_r, bad_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;
  logic               pop_fire;
  logic [POS_W-1:0]   pos_e;
  logic [7:0]         want;
  logic               emit;

  function automatic logic [7:0] pattern_byte(input logic [47:0] pat,
                                              input logic [2:0]  idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = pat[7:0];
      3'd1:    b = pat[15:8];
      3'd2:    b = pat[23:16];
      3'd3:    b = pat[31:24];
      3'd4:    b = pat[39:32];
      3'd5:    b = pat[47:40];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // take a byte whenever the result slot is free or being drained
  assign pop_ready = !out_valid_r || out_tready;
  assign pop_fire  = pop_valid && pop_ready;

  // per-byte framing, header capture and running sums
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    sum_lo_nxt = sum_lo_r;
    sum_hi_nxt = sum_hi_r;
    type_nxt   = type_r;
    sub_nxt    = sub_r;
    len_nxt    = len_r;
    ck_nxt     = ck_r;
    bad_nxt    = bad_r;
    res_nxt    = res_r;
    emit       = 1'b0;
    pos_e      = pos_r;
    want       = 8'h00;
    if (pop_fire && (pop_item.first || state_r == ST_ACTIVE)) begin
      // a flagged byte restarts the packet
      if (pop_item.first) begin
        pos_e      = '0;
        sum_lo_nxt = 8'h00;
        sum_hi_nxt = 8'h00;
        type_nxt   = 8'h00;
        sub_nxt    = 8'h00;
        len_nxt    = 16'h0000;
        ck_nxt     = 16'h0000;
        bad_nxt    = 1'b0;
      end
      state_nxt = ST_ACTIVE;

      // checksum covers everything but the checksum field
      if (pos_e != POS_CK_LO && pos_e != POS_CK_HI) begin
        sum_lo_nxt = sum_lo_nxt + pop_item.data;
        sum_hi_nxt = sum_hi_nxt + sum_lo_nxt;
      end

      // start pattern compare
      want = pattern_byte(start_pattern, pos_e[2:0]);
      if (pos_e < POS_W'(START_LEN) && want != pop_item.data) begin
        bad_nxt = 1'b1;
      end

      // header capture
      if (pos_e == POS_TYPE) begin
        type_nxt = pop_item.data;
      end
      if (pos_e == POS_SUB) begin
        sub_nxt = pop_item.data;
      end
      if (pos_e == POS_LEN_LO) begin
        len_nxt[7:0] = pop_item.data;
      end
      if (pos_e == POS_LEN_HI) begin
        len_nxt[15:8] = pop_item.data;
      end
      if (pos_e == POS_CK_LO) begin
        ck_nxt[7:0] = pop_item.data;
      end
      if (pos_e == POS_CK_HI) begin
        ck_nxt[15:8] = pop_item.data;
      end

      pos_nxt = pos_e + 1'b1;

      priority if (pos_e == POS_W'(START_LEN - 1) && bad_nxt) begin
        emit      = 1'b1;
        state_nxt = ST_DISCARD;
        res_nxt   = '0;
        res_nxt.status = STAT_BAD_START;
      end else if (pos_e >= POS_W'(HEADER_LEN - 1) &&
                   pos_e == POS_W'(HEADER_LEN - 1) + {1'b0, len_nxt}) begin
        emit      = 1'b1;
        state_nxt = ST_DISCARD;
        res_nxt.packet_type       = type_nxt;
        res_nxt.subsector         = sub_nxt;
        res_nxt.payload_len       = len_nxt;
        res_nxt.computed_checksum = {sum_hi_nxt, sum_lo_nxt};
        res_nxt.received_checksum = ck_nxt;
        res_nxt.status = ({sum_hi_nxt, sum_lo_nxt} == ck_nxt) ? STAT_OK : STAT_BAD_SUM;
      end else begin
        emit = 1'b0;
      end
    end
  end

  // result slot
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_DISCARD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    sum_lo_r <= sum_lo_nxt;
    sum_hi_r <= sum_hi_nxt;
    type_r   <= type_nxt;
    sub_r    <= sub_nxt;
    len_r    <= len_nxt;
    ck_r     <= ck_nxt;
    bad_r    <= bad_nxt;
    res_r    <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {res_r.received_checksum, res_r.computed_checksum,
                       res_r.payload_len, res_r.subsector, res_r.packet_type};

`ifndef ASSERT_OFF
  a_bad_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == STAT_BAD_START) |-> (out_tdata == '0))
    else $error("start mismatch result carries nonzero fields");

  a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == STAT_OK) |->
      (res_r.computed_checksum == res_r.received_checksum))
    else $error("ok status with differing checksums");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.status != 2'd3))
    else $error("unused status code on output");
`endif

endmodule

// ===== hdl/packet_deframe_fletcher16_check.sv =====
// Framed packet checker with a Fletcher-16-like checksum (sums mod 256).
// Input stream: one byte per transaction on in_tdata, in_tuser high marks
// the first byte of a packet. Packet layout: start pattern (6 bytes), type,
// subsector, data length (LE), checksum (LE), then the data bytes.
// Result stream: one transaction per packet on out_tdata / out_tuser, given
// after the last byte, or after the last start byte on a start mismatch.
// Configuration: APB write of the 48-bit start pattern at address 0.
// Throughput: one byte per cycle sustained while out_tready stays high;
// the running sums take two 8-bit adds per byte in the back end.
// The packet's last byte passes the input stage and the queue, then the
// result is registered in the result slot.
// Reset clears the queue and result slot; the checker then ignores bytes
// until one arrives with in_tuser high.
// When the result receiver stalls, the result is held, the back end stops
// taking bytes and the queue plus input stage keep accepting until full.
module packet_deframe_fletcher16_check #(
  parameter int START_LEN   = 6,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte
  input  logic        in_tuser,    // first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // packet_type, subsector, payload_len,
                                   // computed_checksum, received_checksum
  output logic [1:0]  out_tuser,   // status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import pdfc_pkg::*;

  localparam logic [2:0] ADDR_START_PATTERN = 3'd0;

  logic        pattern_we;
  logic [47:0] start_pattern_r, start_pattern_nxt;
  logic        f_valid, f_ready;
  item_t       f_item;
  logic        q_valid, q_ready;
  item_t       q_item;

  // configuration register
  assign cfg_pready = 1'b1;
  assign pattern_we = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == ADDR_START_PATTERN);
  assign start_pattern_nxt = pattern_we ? cfg_pwdata[47:0] : start_pattern_r;
  assign cfg_prdata = (cfg_paddr == ADDR_START_PATTERN) ?
                      {16'h0000, start_pattern_r} : 64'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pattern_r <= '0;
    end else begin
      start_pattern_r <= start_pattern_nxt;
    end
  end

  pdfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  pdfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  pdfc_back #(
    .START_LEN (START_LEN)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_pattern (start_pattern_r),
    .pop_valid     (q_valid),
    .pop_ready     (q_ready),
    .pop_item      (q_item),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser)
  );

endmodule

// ===== tb/sv/tb_packet_deframe_fletcher16_check.sv =====
`timescale 1ns / 1ps

module tb_packet_deframe_fletcher16_check;
  import pdfc_pkg::*;

  localparam int START_BYTES = 6;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_BYTES = 300;
  localparam logic [2:0] ADDR_START_PATTERN = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // rx_byte
  logic        in_tuser;    // first_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;   // packet_type, subsector, payload_len,
                            // computed_checksum, received_checksum
  logic [1:0]  out_tuser;   // status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  packet_deframe_fletcher16_check #(
    .START_LEN(START_BYTES)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the checker state
  logic [47:0] start_pat;
  logic [16:0] cur_pos;
  logic [7:0]  run_low;
  logic [7:0]  run_high;
  logic [7:0]  seen_type;
  logic [7:0]  seen_sub;
  logic [15:0] seen_len;
  logic [15:0] seen_sum;
  logic        skipping;
  logic        start_wrong;

  result_t     pending_results[$];
  logic [7:0]  frame[$];
  int          send_idle;
  int          recv_stall;
  int          errors;
  int          bytes_taken;
  int          cycle_count;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // advance the packet checker by one byte; 0 ignored, 1 consumed, 2 result
  function automatic int fletcher_step(input logic [7:0] b, input logic first,
                                       output result_t res);
    logic [15:0] calc;
    logic [7:0]  want;
    int          p;
    res = '0;
    if (first) begin
      cur_pos     = '0;
      run_low     = '0;
      run_high    = '0;
      seen_type   = '0;
      seen_sub    = '0;
      seen_len    = '0;
      seen_sum    = '0;
      start_wrong = 1'b0;
      skipping    = 1'b0;
    end else if (skipping) begin
      return 0;
    end
    p = int'(cur_pos);
    // checksum bytes are left out of the running sums
    if (cur_pos != POS_CK_LO && cur_pos != POS_CK_HI) begin
      run_low  = run_low + b;
      run_high = run_high + run_low;
    end
    if (p < START_BYTES) begin
      want = start_pat[8*p +: 8];
      if (want != b) start_wrong = 1'b1;
      if (p == START_BYTES - 1 && start_wrong) begin
        res.status = STAT_BAD_START;
        skipping = 1'b1;
        return 2;
      end
    end
    case (cur_pos)
      POS_TYPE:   seen_type = b;
      POS_SUB:    seen_sub = b;
      POS_LEN_LO: seen_len[7:0] = b;
      POS_LEN_HI: seen_len[15:8] = b;
      POS_CK_LO:  seen_sum[7:0] = b;
      POS_CK_HI:  seen_sum[15:8] = b;
      default: ;
    endcase
    // last byte of the packet
    if (p >= HEADER_LEN - 1 && p == HEADER_LEN - 1 + int'(seen_len)) begin
      calc = {run_high, run_low};
      res.status            = (calc == seen_sum) ? STAT_OK : STAT_BAD_SUM;
      res.packet_type       = seen_type;
      res.subsector         = seen_sub;
      res.payload_len       = seen_len;
      res.computed_checksum = calc;
      res.received_checksum = seen_sum;
      skipping = 1'b1;
      return 2;
    end
    cur_pos = cur_pos + 17'd1;
    return 1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status            = out_tuser;
      got.packet_type       = out_tdata[7:0];
      got.subsector         = out_tdata[15:8];
      got.payload_len       = out_tdata[31:16];
      got.computed_checksum = out_tdata[47:32];
      got.received_checksum = out_tdata[63:48];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d tdata %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("packet_type", 16'(want.packet_type), 16'(got.packet_type));
        check_field("subsector", 16'(want.subsector), 16'(got.subsector));
        check_field("payload_len", want.payload_len, got.payload_len);
        check_field("computed_checksum", want.computed_checksum,
                    got.computed_checksum);
        check_field("received_checksum", want.received_checksum,
                    got.received_checksum);
      end
    end
  end

  // drive one byte transaction and record what it should produce
  task automatic send_byte(input logic [7:0] b, input logic first);
    result_t res;
    int      kind;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    kind = fletcher_step(b, first, res);
    if (kind == 2) pending_results.push_back(res);
    if (kind != 0) bytes_taken++;
  endtask

  task automatic send_frame(input int from, input int upto);
    for (int i = from; i < upto; i++) send_byte(frame[i], i == 0);
  endtask

  // wait until every expected result is out and the pipeline has emptied
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_pattern(input logic [47:0] value);
    wait_drained();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_START_PATTERN;
    cfg_pwdata  <= {16'h0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    start_pat = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // fill in the checksum bytes, correct or random
  task automatic seal_frame(input logic ck_ok);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = '0;
    hi = '0;
    for (int i = 0; i < frame.size(); i++) begin
      if (i != int'(POS_CK_LO) && i != int'(POS_CK_HI)) begin
        lo = lo + frame[i];
        hi = hi + lo;
      end
    end
    frame[POS_CK_LO] = ck_ok ? lo : 8'($urandom_range(255));
    frame[POS_CK_HI] = ck_ok ? hi : 8'($urandom_range(255));
  endtask

  task automatic make_frame(input logic [47:0] pat, input int len, input logic ck_ok);
    logic [15:0] l16;
    l16 = 16'(len);
    frame.delete();
    for (int k = 0; k < START_BYTES; k++) frame.push_back(pat[8*k +: 8]);
    frame.push_back(8'($urandom_range(255)));
    frame.push_back(8'($urandom_range(255)));
    frame.push_back(l16[7:0]);
    frame.push_back(l16[15:8]);
    frame.push_back(8'h00);
    frame.push_back(8'h00);
    for (int k = 0; k < len; k++) frame.push_back(8'($urandom_range(255)));
    seal_frame(ck_ok);
  endtask

  // bytes without a first-byte flag after reset are dropped
  task automatic test_discard_after_reset();
    send_idle  = 16;
    recv_stall = 50;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (4) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic test_directed_frames();
    send_idle  = 0;
    recv_stall = 0;
    // empty data section, all-zero start pattern
    write_start_pattern(48'h0);
    make_frame(start_pat, 0, 1'b1);
    frame[POS_TYPE] = 8'hFF;
    frame[POS_SUB]  = 8'h00;
    seal_frame(1'b1);
    send_frame(0, frame.size());
    // all-ones pattern, extreme data bytes, checksum mismatch
    write_start_pattern(48'hFFFF_FFFF_FFFF);
    make_frame(start_pat, 2, 1'b1);
    frame[POS_TYPE]  = 8'h00;
    frame[POS_SUB]   = 8'hFF;
    frame[12]        = 8'hFF;
    frame[13]        = 8'h00;
    frame[POS_CK_LO] = 8'hFF;
    frame[POS_CK_HI] = 8'hFF;
    send_frame(0, frame.size());
    // start mismatch on the first and on the last start byte, tail ignored
    write_start_pattern(48'hA5C3_0F96_7E18);
    make_frame(start_pat, 1, 1'b1);
    frame[0] = frame[0] ^ 8'h01;
    send_frame(0, frame.size());
    make_frame(start_pat, 1, 1'b1);
    frame[START_BYTES-1] = frame[START_BYTES-1] ^ 8'h80;
    send_frame(0, frame.size());
    // a new first byte abandons the packet in progress
    make_frame(start_pat, 4, 1'b1);
    send_frame(0, 9);
    make_frame(start_pat, 3, 1'b1);
    send_frame(0, frame.size());
    // pattern rewritten mid-packet applies to the remaining start bytes
    make_frame(48'h1122_3344_5566, 5, 1'b1);
    for (int k = 0; k < 3; k++) frame[k] = start_pat[8*k +: 8];
    seal_frame(1'b1);
    send_frame(0, 3);
    write_start_pattern(48'h1122_3344_5566);
    send_frame(3, frame.size());
  endtask

  // mostly well-formed packets, plus bad starts, cut-off packets and noise
  task automatic test_random_traffic(input int s_idle, input int r_stall,
                                     input int n_bytes, input logic [47:0] pat);
    int base;
    int kind;
    int len;
    int cut;
    int pos;
    send_idle  = s_idle;
    recv_stall = r_stall;
    write_start_pattern(pat);
    base = bytes_taken;
    while (bytes_taken - base < n_bytes) begin
      kind = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(24);
      make_frame(start_pat, len, 1'($urandom_range(1)));
      if (kind < 60) begin
        send_frame(0, frame.size());
      end else if (kind < 72) begin
        pos = $urandom_range(START_BYTES - 1);
        frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
        send_frame(0, frame.size());
      end else if (kind < 84) begin
        frame[POS_LEN_LO] = 8'($urandom_range(255));
        frame[POS_LEN_HI] = 8'($urandom_range(255));
        cut = $urandom_range(1, frame.size() - 1);
        send_frame(0, cut);
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
    end
  endtask

  // largest data length in the header, packet then cut off by a new first byte
  task automatic test_max_length();
    send_idle  = 0;
    recv_stall = 0;
    make_frame(start_pat, 20, 1'b1);
    frame[POS_LEN_LO] = 8'hFF;
    frame[POS_LEN_HI] = 8'hFF;
    send_frame(0, frame.size());
    make_frame(start_pat, 0, 1'b1);
    send_frame(0, frame.size());
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    send_idle   = 0;
    recv_stall  = 0;
    errors      = 0;
    bytes_taken = 0;
    cycle_count = 0;
    // checker state after reset
    start_pat   = '0;
    cur_pos     = '0;
    run_low     = '0;
    run_high    = '0;
    seen_type   = '0;
    seen_sub    = '0;
    seen_len    = '0;
    seen_sum    = '0;
    skipping    = 1'b1;
    start_wrong = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_discard_after_reset();
    test_directed_frames();
    test_random_traffic(16, 82, RANDOM_BYTES, 48'({$urandom, $urandom}));
    test_random_traffic(82, 16, RANDOM_BYTES, 48'({$urandom, $urandom}));
    test_random_traffic(0, 0, RANDOM_BYTES, 48'({$urandom, $urandom}));
    test_max_length();
    wait_drained();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pdfc_pkg.sv
hdl/pdfc_front.sv
hdl/pdfc_queue.sv
hdl/pdfc_back.sv
hdl/packet_deframe_fletcher16_check.sv
tb/sv/tb_packet_deframe_fletcher16_check.sv
